@@ hw/rtl/vector_set_length_2d_macros.svh @@
// Assertion macros for the vector set-length block.
// Used by vector_set_length_2d.sv; empty bodies under SYNTHESIS.
`ifndef VECTOR_SET_LENGTH_2D_MACROS_SVH
`define VECTOR_SET_LENGTH_2D_MACROS_SVH
`ifndef SYNTHESIS
`define VSL_CHECK(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vsl check failed");
`define VSL_CHECK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vsl next-cycle check failed");
`else
`define VSL_CHECK(label, ante, cons)
`define VSL_CHECK_NEXT(label, ante, cons)
`endif
`endif

@@ hw/rtl/vsl2d_pkg.sv @@
// Shared constants for the vector set-length block.
// No dependencies.
`default_nettype none
package vsl2d_pkg;
  localparam int PORT_BITS = 32;
endpackage
`default_nettype wire

@@ hw/rtl/vector_set_length_2d.sv @@
// Vector set-length: rescales (x, y) to a target length, signed fixed point.
// Depends on vsl2d_pkg and vector_set_length_2d_macros.svh.
//
//   channel | signals                               | direction
//   input   | in_valid in_ready in_x in_y target_length | in
//   output  | out_valid out_ready out_x out_y        | out
//
// One item per cycle while the output is not stalled.
// Stages: magnitudes, products, sum, one root bit per stage (WORD_BITS),
// divider load, one quotient bit per stage for both components (WORD_BITS-1),
// output.
// A stall at the output freezes the whole pipeline; nothing is lost.
// Reset clears only the stage valid bits.
`default_nettype none
`include "vector_set_length_2d_macros.svh"
module vector_set_length_2d #(
  parameter int WORD_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_x,
  input  wire logic [31:0] in_y,
  input  wire logic [31:0] target_length,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      out_x,
  output logic [31:0]      out_y
);
  localparam int W  = WORD_BITS;
  localparam int W2 = 2 * WORD_BITS;
  localparam int PB = vsl2d_pkg::PORT_BITS;

  typedef struct packed {
    logic          xneg;
    logic          yneg;
    logic          kill;
    logic [W-1:0]  tm;
    logic [W2-1:0] px;
    logic [W2-1:0] py;
  } side_t;

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // magnitudes
  logic [W-1:0] rx, ry, rt;
  assign rx = in_x[W-1:0];
  assign ry = in_y[W-1:0];
  assign rt = target_length[W-1:0];

  logic         a_valid;
  logic [W-1:0] a_xm, a_ym, a_tm;
  logic         a_xneg, a_yneg, a_kill;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
    if (adv) begin
      a_xm   <= rx[W-1] ? (~rx + 1'b1) : rx;
      a_ym   <= ry[W-1] ? (~ry + 1'b1) : ry;
      a_tm   <= rt[W-1] ? (~rt + 1'b1) : rt;
      a_xneg <= rx[W-1];
      a_yneg <= ry[W-1];
      a_kill <= rt[W-1] || (rt == '0);
    end
  end

  // products
  logic [W2-1:0] mul_xx, mul_yy, mul_xt, mul_yt;
  assign mul_xx = a_xm * a_xm;
  assign mul_yy = a_ym * a_ym;
  assign mul_xt = a_xm * a_tm;
  assign mul_yt = a_ym * a_tm;

  logic          b_valid;
  logic [W2-1:0] b_sqx, b_sqy;
  side_t         b_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
    if (adv) begin
      b_sqx       <= mul_xx;
      b_sqy       <= mul_yy;
      b_side.xneg <= a_xneg;
      b_side.yneg <= a_yneg;
      b_side.kill <= a_kill;
      b_side.tm   <= a_tm;
      b_side.px   <= mul_xt;
      b_side.py   <= mul_yt;
    end
  end

  // square root, one bit per stage
  logic          s_valid [0:W];
  logic [W+1:0]  s_rem   [0:W];
  logic [W-1:0]  s_root  [0:W];
  logic [W2-1:0] s_v     [0:W];
  side_t         s_side  [0:W];

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid[0] <= 1'b0;
    end else if (adv) begin
      s_valid[0] <= b_valid;
    end
    if (adv) begin
      s_v[0]    <= b_sqx + b_sqy;
      s_rem[0]  <= '0;
      s_root[0] <= '0;
      s_side[0] <= b_side;
    end
  end

  for (genvar i = 0; i < W; i++) begin : g_sqrt
    logic [W+3:0] r2, trial, diff;
    logic         ge;
    assign r2    = {s_rem[i], s_v[i][W2-1 -: 2]};
    assign trial = {2'b00, s_root[i], 2'b01};
    assign ge    = r2 >= trial;
    assign diff  = r2 - trial;
    always_ff @(posedge clk) begin
      if (rst) begin
        s_valid[i+1] <= 1'b0;
      end else if (adv) begin
        s_valid[i+1] <= s_valid[i];
      end
      if (adv) begin
        s_rem[i+1]  <= ge ? diff[W+1:0] : r2[W+1:0];
        s_root[i+1] <= {s_root[i][W-2:0], ge};
        s_v[i+1]    <= s_v[i] << 2;
        s_side[i+1] <= s_side[i];
      end
    end
  end

  // two dividers, one quotient bit per stage
  logic         d_valid [0:W-1];
  logic [W-1:0] d_len   [0:W-1];
  logic [W:0]   d_rx    [0:W-1];
  logic [W:0]   d_ry    [0:W-1];
  logic [W-2:0] d_qx    [0:W-1];
  logic [W-2:0] d_qy    [0:W-1];
  side_t        d_side  [0:W-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid[0] <= 1'b0;
    end else if (adv) begin
      d_valid[0] <= s_valid[W];
    end
    if (adv) begin
      d_len[0]  <= s_root[W];
      d_rx[0]   <= s_side[W].px[W2-1:W-1];
      d_ry[0]   <= s_side[W].py[W2-1:W-1];
      d_qx[0]   <= '0;
      d_qy[0]   <= '0;
      d_side[0] <= s_side[W];
    end
  end

  for (genvar j = 0; j < W - 1; j++) begin : g_div
    localparam int K = W - 2 - j;
    logic [W:0] rx2, ry2, lenx;
    logic       gex, gey;
    assign rx2  = {d_rx[j][W-1:0], d_side[j].px[K]};
    assign ry2  = {d_ry[j][W-1:0], d_side[j].py[K]};
    assign lenx = {1'b0, d_len[j]};
    assign gex  = rx2 >= lenx;
    assign gey  = ry2 >= lenx;
    always_ff @(posedge clk) begin
      if (rst) begin
        d_valid[j+1] <= 1'b0;
      end else if (adv) begin
        d_valid[j+1] <= d_valid[j];
      end
      if (adv) begin
        d_len[j+1]  <= d_len[j];
        d_rx[j+1]   <= gex ? (rx2 - lenx) : rx2;
        d_ry[j+1]   <= gey ? (ry2 - lenx) : ry2;
        d_qx[j+1]   <= {d_qx[j][W-3:0], gex};
        d_qy[j+1]   <= {d_qy[j][W-3:0], gey};
        d_side[j+1] <= d_side[j];
      end
    end
  end

  // sign, special cases, output register
  side_t               l_side;
  logic signed [W-1:0] l_qx, l_qy, sx, sy;
  logic [PB-1:0]       res_x, res_y;

  assign l_side = d_side[W-1];
  assign l_qx   = {1'b0, d_qx[W-1]};
  assign l_qy   = {1'b0, d_qy[W-1]};
  assign sx     = l_side.xneg ? -l_qx : l_qx;
  assign sy     = l_side.yneg ? -l_qy : l_qy;

  always_comb begin
    if (l_side.kill) begin
      res_x = '0;
      res_y = '0;
    end else if (d_len[W-1] == '0) begin
      res_x = PB'(l_side.tm);
      res_y = '0;
    end else begin
      res_x = PB'(sx);
      res_y = PB'(sy);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid[W-1];
    end
    if (adv) begin
      out_x <= res_x;
      out_y <= res_y;
    end
  end

  `VSL_CHECK(a_ready_rule, 1'b1, in_ready == (!out_valid || out_ready))
  `VSL_CHECK_NEXT(a_kill_zero, adv && d_valid[W-1] && l_side.kill, out_valid && out_x == '0 && out_y == '0)
  `VSL_CHECK(a_div_rem, d_valid[W-1] && !l_side.kill && d_len[W-1] != '0, d_rx[W-1] < {1'b0, d_len[W-1]} && d_ry[W-1] < {1'b0, d_len[W-1]})
  `VSL_CHECK(a_sqrt_rem, s_valid[W], s_rem[W] <= {1'b0, s_root[W], 1'b0})
  `VSL_CHECK_NEXT(a_stall_hold, out_valid && !out_ready, $stable(d_valid[0]))
endmodule
`default_nettype wire

@@ dv/vector_set_length_2d_checker.sv @@
// Scoreboard for vector_set_length_2d: watches both channels, predicts each
// rescaled vector from the accepted input and compares. Depends on vsl2d_pkg.
module vector_set_length_2d_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  input  wire logic                            in_ready,
  input  wire logic [vsl2d_pkg::PORT_BITS-1:0] in_x,
  input  wire logic [vsl2d_pkg::PORT_BITS-1:0] in_y,
  input  wire logic [vsl2d_pkg::PORT_BITS-1:0] target_length,
  input  wire logic                            out_valid,
  input  wire logic                            out_ready,
  input  wire logic [vsl2d_pkg::PORT_BITS-1:0] out_x,
  input  wire logic [vsl2d_pkg::PORT_BITS-1:0] out_y,
  output int                                   errors,
  output int                                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
  } vec_t;

  vec_t scaled_q[$];

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] rem;
    logic [63:0] trial;
    root = 0;
    rem = v;
    for (int b = 31; b >= 0; b--) begin
      trial = ((root << 1) | (64'd1 << b)) << b;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | (64'd1 << b);
      end
    end
    return root;
  endfunction

  function automatic logic [31:0] mag(logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  function automatic vec_t rescale(logic [31:0] x, logic [31:0] y, logic [31:0] t);
    vec_t r;
    logic [63:0] xm, ym, tm, len, qx, qy;
    xm = {32'd0, mag(x)};
    ym = {32'd0, mag(y)};
    tm = {32'd0, t};
    r = '0;
    if (t[31] || t == 0) return r;
    len = floor_root(xm * xm + ym * ym);
    if (len == 0) begin
      r.x = t;
      return r;
    end
    qx = (xm * tm) / len;
    qy = (ym * tm) / len;
    r.x = qx[31:0];
    r.y = qy[31:0];
    if (x[31]) r.x = -r.x;
    if (y[31]) r.y = -r.y;
    return r;
  endfunction

  always @(posedge clk) begin
    vec_t e;
    if (rst) begin
      errors <= 0;
      pending <= 0;
    end else begin
      if (in_valid && in_ready) scaled_q.push_back(rescale(in_x, in_y, target_length));
      if (out_valid && out_ready) begin
        if (scaled_q.size() == 0) begin
          if (errors < 10) $display("unexpected item x=%h y=%h", out_x, out_y);
          errors <= errors + 1;
        end else begin
          e = scaled_q.pop_front();
          if (e.x !== out_x || e.y !== out_y) begin
            if (errors < 10)
              $display("mismatch: expected x=%h y=%h got x=%h y=%h", e.x, e.y, out_x, out_y);
            errors <= errors + 1;
          end
        end
      end
      pending <= scaled_q.size();
    end
  end
endmodule

@@ dv/vector_set_length_2d_tb.sv @@
// Testbench top for vector_set_length_2d: drives directed and random vectors
// under several idle patterns. Depends on the block and the checker.
module vector_set_length_2d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 68;
  localparam int CYCLE_LIMIT = 400000;

  logic clk = 0, rst = 1, in_valid = 0, out_ready = 0, in_ready, out_valid;
  logic [31:0] in_x = 0, in_y = 0, target_length = 0, out_x, out_y;
  int errors, pending, cycles = 0;
  int send_idle = 0, recv_stall = 0;

  vector_set_length_2d u_dut (.*);
  vector_set_length_2d_checker u_chk (.*);

  initial forever #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= !rst && ($urandom_range(99) >= recv_stall);

  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0: return $urandom_range(1) ? 32'h7fffffff : 32'h80000000;
      1: return $urandom_range(255) - 128;
      2: return $urandom_range(32'h3ffff) - 32'h20000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_vec(logic [31:0] x, logic [31:0] y, logic [31:0] t);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(negedge clk);
    end
    in_valid <= 1;
    in_x <= x;
    in_y <= y;
    target_length <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    logic [31:0] t;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    send_vec(0, 0, 32'h10000);
    send_vec(0, 0, 0);
    send_vec(32'h10000, 0, 0);
    send_vec(32'h10000, 32'h10000, 32'hffff0000);
    send_vec(32'h10000, 32'h10000, 32'h80000000);
    send_vec(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
    send_vec(32'h80000000, 32'h80000000, 32'h7fffffff);
    send_vec(32'h80000000, 0, 32'h7fffffff);
    send_vec(0, 32'h80000000, 1);
    send_vec(1, 0, 32'h7fffffff);
    send_vec(32'hffffffff, 32'hffffffff, 32'h7fffffff);
    send_vec(32'h30000, 32'hfffc0000, 32'h50000);
    send_vec(32'hffffffff, 1, 32'h10000);
    send_vec(32'h7fffffff, 32'h80000000, 1);
    send_vec(0, 0, 32'h7fffffff);
    for (int i = 0; i < 1440; i++) begin
      case (i / 360)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 56; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 56; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      if (i % 360 > 330) begin send_idle = 0; recv_stall = 0; end
      t = rand_word();
      if ($urandom_range(9) != 0) t[31] = 0;
      if ($urandom_range(19) == 0) send_vec(0, 0, t);
      else send_vec(rand_word(), rand_word(), t);
    end
    in_valid <= 0;
    recv_stall = 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (errors == 0 && pending == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
